// ----- rtl/ufs_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ufs_pkg
// Shared constants and types for the disjoint-set (union by size) block.
// ----------------------------------------------------------------------------
package ufs_pkg;

   // forest geometry
   localparam int NODES  = 1024;
   localparam int NODE_W = $clog2(NODES);
   localparam int SIZE_W = $clog2(NODES + 1);

   // node count register
   localparam int CNT_W = 11;
   localparam logic [CNT_W-1:0] COUNT_RESET = CNT_W'(NODES);

   // stream payload widths, padded to whole bytes
   localparam int REQ_DATA_W = ((2 * NODE_W + 7) / 8) * 8;
   localparam int RSP_DATA_W = ((NODE_W + 1 + SIZE_W + 7) / 8) * 8;

   // operation codes
   localparam logic FUNC_FIND  = 1'b0;
   localparam logic FUNC_UNION = 1'b1;

   // shared compare / add unit result
   typedef struct packed {
      logic              eq;
      logic              lt;
      logic [SIZE_W-1:0] sum;
   } alu_res_type;

endpackage

// ----- rtl/ufs_ram.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ufs_ram
// Generic single-write, single-read memory with registered read data.
// ----------------------------------------------------------------------------
module ufs_ram #(
   parameter int DEPTH = 1024,
   parameter int WIDTH = 10
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // write port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
   end

   // registered read port
   always_ff @(posedge clock) begin
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

// ----- rtl/ufs_alu.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ufs_alu
// Shared compare and add unit, used for link checks, root checks and sizes.
// ----------------------------------------------------------------------------
module ufs_alu (
   input  logic [ufs_pkg::SIZE_W-1:0] opa,
   input  logic [ufs_pkg::SIZE_W-1:0] opb,
   output ufs_pkg::alu_res_type       res
);

   // one comparator and one adder on the same operand pair
   always_comb begin
      res.eq  = (opa == opb);
      res.lt  = (opa < opb);
      res.sum = opa + opb;
   end

endmodule

// ----- rtl/union_find_by_size.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// union_find_by_size
// Disjoint-set forest with union by size and iterative path compression.
// ----------------------------------------------------------------------------
// After reset the block runs a clearing pass over all NODES (1024) entries
// that sets every node to a singleton. req_tready stays low during it, and
// configuration writes are taken. One transaction is worked at a time.
// Every step follows one parent link, since the parent memory has a single
// read port. The steps of each transaction, in order:
// - a find walks from the node to its root, compresses the path if the walk
//   moved, then does the root check, size lookup, output load and idle
// - a union does two walks with compression and a root check after each,
//   then the two size reads with the link and the output load; when both
//   nodes already share a root a single size read takes their place
// With union by size trees stay at most 10 deep. An index error skips the
// walks and goes straight to the output load. A new request is accepted
// while a finished result still waits on the rsp side.
// ----------------------------------------------------------------------------
module union_find_by_size (
   input  logic                               clock,
   input  logic                               reset,
   // request: node_a [9:0], node_b [19:10], zero pad
   input  logic                               req_tvalid,
   output logic                               req_tready,
   input  logic [ufs_pkg::REQ_DATA_W-1:0]     req_tdata,
   // request user: func [0]
   input  logic                               req_tuser,
   // response: root [9:0], joined [10], group_size [21:11], zero pad
   output logic                               rsp_tvalid,
   input  logic                               rsp_tready,
   output logic [ufs_pkg::RSP_DATA_W-1:0]     rsp_tdata,
   // response user: index_error [0]
   output logic                               rsp_tuser,
   // node count register
   input  logic                               csr_wen,
   input  logic [ufs_pkg::CNT_W-1:0]          csr_wdata
);

   localparam int NW = ufs_pkg::NODE_W;
   localparam int SW = ufs_pkg::SIZE_W;
   localparam int CW = ufs_pkg::CNT_W;

   typedef enum logic [3:0] {
      ST_CLEAR, ST_IDLE, ST_WALK, ST_COMP, ST_FOUND,
      ST_SIZE_A, ST_SIZE_B, ST_SIZE_ONE, ST_OUT
   } state_type;

   state_type         state_ff, state_in;
   logic [NW-1:0]     clr_ff, clr_in;
   logic [CW-1:0]     count_ff, count_in;
   logic              func_ff, func_in;
   logic [NW-1:0]     node_b_ff, node_b_in;
   logic [NW-1:0]     start_ff, start_in;
   logic [NW-1:0]     walk_ff, walk_in;
   logic [NW-1:0]     root_ff, root_in;
   logic              moved_ff, moved_in;
   logic              phase_ff, phase_in;
   logic [NW-1:0]     ra_ff, ra_in;
   logic [SW-1:0]     sa_ff, sa_in;
   logic [NW-1:0]     res_root_ff, res_root_in;
   logic              res_join_ff, res_join_in;
   logic [SW-1:0]     res_size_ff, res_size_in;
   logic              res_err_ff, res_err_in;
   logic              rsp_valid_ff, rsp_valid_in;
   logic [ufs_pkg::RSP_DATA_W-1:0] rsp_data_ff, rsp_data_in;
   logic              rsp_user_ff, rsp_user_in;

   // memory ports
   logic              par_we, sz_we;
   logic [NW-1:0]     par_waddr, par_wdata, par_raddr, par_rdata;
   logic [NW-1:0]     sz_waddr, sz_raddr;
   logic [SW-1:0]     sz_wdata, sz_rdata;

   // shared unit
   logic [SW-1:0]        alu_a, alu_b;
   ufs_pkg::alu_res_type alu_res;

   // request fields and checks
   logic [NW-1:0]     req_a, req_b;
   logic [CW-1:0]     lim;
   logic              req_err, req_acc, out_free;

   assign req_a = req_tdata[NW-1:0];
   assign req_b = req_tdata[2*NW-1:NW];

   // effective node count, capped at the forest size
   assign lim = (count_ff > CW'(ufs_pkg::NODES)) ? CW'(ufs_pkg::NODES) : count_ff;
   assign req_err = (CW'(req_a) >= lim) ||
                    ((req_tuser == ufs_pkg::FUNC_UNION) && (CW'(req_b) >= lim));

   assign req_tready = (state_ff == ST_IDLE);
   assign req_acc    = req_tvalid && req_tready;
   assign out_free   = !rsp_valid_ff || rsp_tready;

   ufs_ram #(.DEPTH(ufs_pkg::NODES), .WIDTH(NW)) u_parent (
      .clock   (clock),
      .wr_en   (par_we),
      .wr_addr (par_waddr),
      .wr_data (par_wdata),
      .rd_addr (par_raddr),
      .rd_data (par_rdata)
   );

   ufs_ram #(.DEPTH(ufs_pkg::NODES), .WIDTH(SW)) u_size (
      .clock   (clock),
      .wr_en   (sz_we),
      .wr_addr (sz_waddr),
      .wr_data (sz_wdata),
      .rd_addr (sz_raddr),
      .rd_data (sz_rdata)
   );

   ufs_alu u_alu (
      .opa (alu_a),
      .opb (alu_b),
      .res (alu_res)
   );

   // sequencer next-state and memory control
   always_comb begin
      state_in    = state_ff;
      clr_in      = clr_ff;
      count_in    = csr_wen ? csr_wdata : count_ff;
      func_in     = func_ff;
      node_b_in   = node_b_ff;
      start_in    = start_ff;
      walk_in     = walk_ff;
      root_in     = root_ff;
      moved_in    = moved_ff;
      phase_in    = phase_ff;
      ra_in       = ra_ff;
      sa_in       = sa_ff;
      res_root_in = res_root_ff;
      res_join_in = res_join_ff;
      res_size_in = res_size_ff;
      res_err_in  = res_err_ff;
      par_we      = 1'b0;
      par_waddr   = walk_ff;
      par_wdata   = root_ff;
      par_raddr   = walk_ff;
      sz_we       = 1'b0;
      sz_waddr    = root_ff;
      sz_wdata    = alu_res.sum;
      sz_raddr    = root_ff;
      alu_a       = SW'(par_rdata);
      alu_b       = SW'(walk_ff);

      // output holding register drains independently
      rsp_valid_in = (rsp_valid_ff && !rsp_tready);
      rsp_data_in  = rsp_data_ff;
      rsp_user_in  = rsp_user_ff;

      unique case (state_ff)
         // write every node as a singleton
         ST_CLEAR: begin
            par_we    = 1'b1;
            par_waddr = clr_ff;
            par_wdata = clr_ff;
            sz_we     = 1'b1;
            sz_waddr  = clr_ff;
            sz_wdata  = SW'(1);
            clr_in    = clr_ff + NW'(1);
            if (clr_ff == NW'(ufs_pkg::NODES - 1)) begin
               state_in = ST_IDLE;
            end
         end
         // take a transaction, start the first walk
         ST_IDLE: begin
            par_raddr = req_a;
            if (req_acc) begin
               func_in   = req_tuser;
               node_b_in = req_b;
               start_in  = req_a;
               walk_in   = req_a;
               moved_in  = 1'b0;
               phase_in  = 1'b0;
               if (req_err) begin
                  res_root_in = '0;
                  res_join_in = 1'b0;
                  res_size_in = '0;
                  res_err_in  = 1'b1;
                  state_in    = ST_OUT;
               end else begin
                  res_err_in = 1'b0;
                  state_in   = ST_WALK;
               end
            end
         end
         // follow parent links until a node points at itself
         ST_WALK: begin
            alu_a = SW'(par_rdata);
            alu_b = SW'(walk_ff);
            if (alu_res.eq) begin
               root_in = walk_ff;
               if (moved_ff) begin
                  walk_in   = start_ff;
                  par_raddr = start_ff;
                  state_in  = ST_COMP;
               end else begin
                  state_in = ST_FOUND;
               end
            end else begin
               walk_in   = par_rdata;
               moved_in  = 1'b1;
               par_raddr = par_rdata;
            end
         end
         // repoint each node on the path at the root
         ST_COMP: begin
            alu_a     = SW'(par_rdata);
            alu_b     = SW'(root_ff);
            par_we    = 1'b1;
            par_waddr = walk_ff;
            par_wdata = root_ff;
            par_raddr = par_rdata;
            walk_in   = par_rdata;
            if (alu_res.eq) begin
               state_in = ST_FOUND;
            end
         end
         // one find done: next find, size lookup or root compare
         ST_FOUND: begin
            alu_a = SW'(ra_ff);
            alu_b = SW'(root_ff);
            if (func_ff == ufs_pkg::FUNC_FIND) begin
               sz_raddr    = root_ff;
               res_root_in = root_ff;
               res_join_in = 1'b0;
               state_in    = ST_SIZE_ONE;
            end else if (!phase_ff) begin
               ra_in     = root_ff;
               start_in  = node_b_ff;
               walk_in   = node_b_ff;
               par_raddr = node_b_ff;
               moved_in  = 1'b0;
               phase_in  = 1'b1;
               state_in  = ST_WALK;
            end else if (alu_res.eq) begin
               sz_raddr    = ra_ff;
               res_root_in = ra_ff;
               res_join_in = 1'b0;
               state_in    = ST_SIZE_ONE;
            end else begin
               sz_raddr = ra_ff;
               state_in = ST_SIZE_A;
            end
         end
         // size of a's root arrives, fetch b's root size
         ST_SIZE_A: begin
            sa_in    = sz_rdata;
            sz_raddr = root_ff;
            state_in = ST_SIZE_B;
         end
         // link the smaller root under the larger one
         ST_SIZE_B: begin
            alu_a       = sa_ff;
            alu_b       = sz_rdata;
            par_we      = 1'b1;
            sz_we       = 1'b1;
            sz_wdata    = alu_res.sum;
            res_join_in = 1'b1;
            res_size_in = alu_res.sum;
            if (alu_res.lt) begin
               par_waddr   = ra_ff;
               par_wdata   = root_ff;
               sz_waddr    = root_ff;
               res_root_in = root_ff;
            end else begin
               par_waddr   = root_ff;
               par_wdata   = ra_ff;
               sz_waddr    = ra_ff;
               res_root_in = ra_ff;
            end
            state_in = ST_OUT;
         end
         // size of an unchanged root
         ST_SIZE_ONE: begin
            res_size_in = sz_rdata;
            state_in    = ST_OUT;
         end
         // hand the result to the output register
         ST_OUT: begin
            if (out_free) begin
               rsp_valid_in = 1'b1;
               rsp_data_in  = ufs_pkg::RSP_DATA_W'({res_size_ff, res_join_ff, res_root_ff});
               rsp_user_in  = res_err_ff;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // state and registered outputs
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_CLEAR;
         clr_ff       <= '0;
         count_ff     <= ufs_pkg::COUNT_RESET;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         clr_ff       <= clr_in;
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      func_ff     <= func_in;
      node_b_ff   <= node_b_in;
      start_ff    <= start_in;
      walk_ff     <= walk_in;
      root_ff     <= root_in;
      moved_ff    <= moved_in;
      phase_ff    <= phase_in;
      ra_ff       <= ra_in;
      sa_ff       <= sa_in;
      res_root_ff <= res_root_in;
      res_join_ff <= res_join_in;
      res_size_ff <= res_size_in;
      res_err_ff  <= res_err_in;
      rsp_data_ff <= rsp_data_in;
      rsp_user_ff <= rsp_user_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;
   assign rsp_tuser  = rsp_user_ff;

endmodule

// ----- rtl/ufs_checker.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ufs_checker
// Port-level checks for the disjoint-set block, bound to the top level.
// ----------------------------------------------------------------------------
module ufs_checker (
   input logic                           clock,
   input logic                           reset,
   input logic                           req_tvalid,
   input logic                           req_tready,
   input logic                           rsp_tvalid,
   input logic                           rsp_tready,
   input logic [ufs_pkg::RSP_DATA_W-1:0] rsp_tdata,
   input logic                           rsp_tuser
);

   localparam int NW = ufs_pkg::NODE_W;
   localparam int SW = ufs_pkg::SIZE_W;

   // a stalled response holds its payload
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tuser))
      else $error("response changed while stalled");

   // the block is busy right after taking a transaction
   a_busy_after_accept: assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready |=> !req_tready)
      else $error("request accepted while busy");

   // an index error carries all-zero fields
   a_err_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tuser |-> rsp_tdata == '0)
      else $error("index error with nonzero fields");

   // a good result always reports a nonempty set, a merge at least two nodes
   a_size_valid: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tuser |->
         (rsp_tdata[NW+SW:NW+1] != '0) &&
         (!rsp_tdata[NW] || (rsp_tdata[NW+SW:NW+1] > SW'(1))))
      else $error("bad group size");

endmodule

bind union_find_by_size ufs_checker u_ufs_checker (
   .clock      (clock),
   .reset      (reset),
   .req_tvalid (req_tvalid),
   .req_tready (req_tready),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata),
   .rsp_tuser  (rsp_tuser)
);
